### design/nir_pkg.sv
// ----------------------------------------------------------------------------
// nir_pkg
// Shared types, constants and saturating helpers for the Newton root unit.
// ----------------------------------------------------------------------------
package nir_pkg;

    localparam int DEF_MAX_ORDER      = 16;
    localparam int DEF_MAX_ITERATIONS = 64;

    localparam logic [63:0] Q_ONE     = 64'h0000_0001_0000_0000;
    localparam logic [31:0] TOL_FLOOR = 32'd430;   // first Q0.32 code not below 1e-7

    typedef logic [2:0] status_t;
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_ORDER0    = 3'd1;
    localparam status_t ST_TOL_SMALL = 3'd2;
    localparam status_t ST_EVEN_NEG  = 3'd3;
    localparam status_t ST_NEG_EVEN  = 3'd4;
    localparam status_t ST_NEG_ODD0  = 3'd5;
    localparam status_t ST_NOCONV    = 3'd6;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Apply sign to a magnitude and clamp to the signed 64-bit range.
    function automatic logic [63:0] sat64(input logic neg, input logic [63:0] m,
                                          input logic big);
        logic [63:0] r;
        begin
            if (neg)
            begin
                if (big || m[63]) r = 64'h8000_0000_0000_0000;
                else              r = 64'd0 - m;
            end
            else
            begin
                if (big || m[63]) r = 64'h7FFF_FFFF_FFFF_FFFF;
                else              r = m;
            end
            return r;
        end
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        begin
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63])
                return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            return s[63:0];
        end
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        begin
            s = {a[63], a} - {b[63], b};
            if (s[64] != s[63])
                return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            return s[63:0];
        end
    endfunction

endpackage

### design/nir_in_if.sv
// ----------------------------------------------------------------------------
// nir_in_if
// Input channel: radicand, root order and tolerance with valid/ready.
// ----------------------------------------------------------------------------
interface nir_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] radicand;
    logic signed [5:0]  root_order;
    logic [31:0]        tolerance;

    modport source (output valid, output radicand, output root_order,
                    output tolerance, input ready);
    modport sink   (input valid, input radicand, input root_order,
                    input tolerance, output ready);
endinterface

### design/nir_out_if.sv
// ----------------------------------------------------------------------------
// nir_out_if
// Output channel: root value and status with valid/ready.
// ----------------------------------------------------------------------------
interface nir_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] root_value;
    logic [2:0]         status;

    modport source (output valid, output root_value, output status, input ready);
    modport sink   (input valid, input root_value, input status, output ready);
endinterface

### design/newton_integer_root_unit.sv
// ----------------------------------------------------------------------------
// newton_integer_root_unit
// Q32.32 k-th root by Newton iteration on a bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
// Timing: a rejected item's result is valid in the cycle after it is accepted.
//   Otherwise each Newton step forms y^(n-1) on the serial multiplier, then runs
//   the x/p and divide-by-n passes on the serial divider and the control states,
//   for at most MAX_ITERATIONS steps, followed by a reciprocal for a negative order.
// Throughput: one item at a time; the serial multiplier/divider sets the pace.
// Reset: rst_n clears the controller to idle and drops the output valid.
module newton_integer_root_unit
    import nir_pkg::*;
#(
    parameter int MAX_ORDER      = DEF_MAX_ORDER,
    parameter int MAX_ITERATIONS = DEF_MAX_ITERATIONS
)
(
    input  logic       clk,
    input  logic       rst_n,
    nir_in_if.sink     in_ch,
    nir_out_if.source  out_ch
);

    localparam int NW  = $clog2(MAX_ORDER + 1);
    localparam int ITW = $clog2(MAX_ITERATIONS + 1);
    localparam logic [6:0] MUL_STEPS = 7'd63;   // 64 multiplier bits
    localparam logic [6:0] DIV_STEPS = 7'd95;   // 96 dividend bits

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PWR   = 9'b000000010,  // decide: next multiply or the x/p divide
        S_MUL   = 9'b000000100,
        S_QDIV  = 9'b000001000,
        S_SUB   = 9'b000010000,  // form x/p - y, start divide by n
        S_NDIV  = 9'b000100000,
        S_UPD   = 9'b001000000,
        S_RECIP = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [63:0]       x_reg, x_next;
    logic [31:0]       tol_reg, tol_next;
    logic [NW-1:0]     n_reg, n_next;
    logic [NW-1:0]     j_reg, j_next;
    logic              negk_reg, negk_next;
    logic [ITW-1:0]    it_reg, it_next;
    logic [63:0]       y_reg, y_next;
    logic [63:0]       p_reg, p_next;
    logic [63:0]       q_reg, q_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    // multiplier
    logic [63:0]       mcand_reg, mcand_next;
    logic [63:0]       mplier_reg, mplier_next;
    logic [63:0]       acc_hi_reg, acc_hi_next;
    logic [63:0]       acc_lo_reg, acc_lo_next;
    // divider
    logic [95:0]       num_reg, num_next;
    logic [63:0]       den_reg, den_next;
    logic [63:0]       rem_reg, rem_next;
    logic [63:0]       quo_reg, quo_next;
    logic              big_reg, big_next;
    // result
    logic [63:0]       res_value_reg, res_value_next;
    status_t           res_status_reg, res_status_next;

    // combinational step values
    logic [64:0]       mul_sum;
    logic [63:0]       mul_hi, mul_lo;
    logic [63:0]       rem_sh;
    logic              qbit;
    logic [63:0]       div_quo;
    logic              div_big;
    logic [63:0]       div_val;
    logic [63:0]       mul_val;
    logic [63:0]       sub_val;
    logic [63:0]       y_upd;
    logic [6:0]        kin_mag;
    logic [NW-1:0]     n_in;
    logic [ITW:0]      it_inc;

    // one bit of the shift-add multiplier
    always_comb
    begin
        mul_sum = {1'b0, acc_hi_reg} + (mplier_reg[0] ? {1'b0, mcand_reg} : 65'd0);
        mul_hi  = mul_sum[64:1];
        mul_lo  = {mul_sum[0], acc_lo_reg[63:1]};
        mul_val = sat64(neg_reg, {mul_hi[31:0], mul_lo[63:32]}, mul_hi[63:32] != 32'd0);
    end

    // one bit of the restoring divider
    always_comb
    begin
        rem_sh  = {rem_reg[62:0], num_reg[95]};
        qbit    = rem_reg[63] || (rem_sh >= den_reg);
        div_quo = {quo_reg[62:0], qbit};
        div_big = big_reg || quo_reg[63];
        div_val = sat64(neg_reg, div_quo, div_big);
    end

    always_comb
    begin
        kin_mag = in_ch.root_order[5] ? (7'd0 - {in_ch.root_order[5], in_ch.root_order})
                                      : {1'b0, in_ch.root_order};
        if (int'(kin_mag) > MAX_ORDER) n_in = NW'(MAX_ORDER);
        else                           n_in = NW'(kin_mag);
        sub_val = sat_sub(q_reg, y_reg);
        y_upd   = sat_add(y_reg, q_reg);
        it_inc  = {1'b0, it_reg} + 1'b1;
    end

    always_comb
    begin
        state_next      = state_reg;
        x_next          = x_reg;
        tol_next        = tol_reg;
        n_next          = n_reg;
        j_next          = j_reg;
        negk_next       = negk_reg;
        it_next         = it_reg;
        y_next          = y_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        cnt_next        = cnt_reg;
        neg_next        = neg_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        acc_hi_next     = acc_hi_reg;
        acc_lo_next     = acc_lo_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        big_next        = big_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    x_next          = in_ch.radicand;
                    tol_next        = in_ch.tolerance;
                    n_next          = n_in;
                    negk_next       = in_ch.root_order[5];
                    y_next          = Q_ONE;
                    p_next          = Q_ONE;
                    j_next          = NW'(1);
                    it_next         = '0;
                    res_value_next  = '0;
                    res_status_next = ST_OK;
                    state_next      = S_PWR;
                    // screen the inputs in priority order
                    if (in_ch.root_order == 6'sd0)
                    begin
                        res_status_next = ST_ORDER0;
                        state_next      = S_OUT;
                    end
                    else if (in_ch.tolerance < TOL_FLOOR)
                    begin
                        res_status_next = ST_TOL_SMALL;
                        state_next      = S_OUT;
                    end
                    else if (!in_ch.root_order[5])
                    begin
                        if (!n_in[0] && in_ch.radicand[63])
                        begin
                            res_status_next = ST_EVEN_NEG;
                            state_next      = S_OUT;
                        end
                    end
                    else
                    begin
                        if (!n_in[0] && (in_ch.radicand[63] || in_ch.radicand == 64'sd0))
                        begin
                            res_status_next = ST_NEG_EVEN;
                            state_next      = S_OUT;
                        end
                        else if (n_in[0] && in_ch.radicand == 64'sd0)
                        begin
                            res_status_next = ST_NEG_ODD0;
                            state_next      = S_OUT;
                        end
                    end
                end
            end

            S_PWR:
            begin
                if (j_reg < n_reg)
                begin
                    mcand_next  = mag64(p_reg);
                    mplier_next = mag64(y_reg);
                    neg_next    = p_reg[63] ^ y_reg[63];
                    acc_hi_next = '0;
                    acc_lo_next = '0;
                    cnt_next    = MUL_STEPS;
                    state_next  = S_MUL;
                end
                else
                begin
                    neg_next = x_reg[63] ^ p_reg[63];
                    if (p_reg == 64'd0)
                    begin
                        // zero divisor: saturate toward the sign of x
                        q_next     = sat64(x_reg[63], 64'd0, x_reg != 64'd0);
                        state_next = S_SUB;
                    end
                    else
                    begin
                        num_next   = {mag64(x_reg), 32'd0};
                        den_next   = mag64(p_reg);
                        rem_next   = '0;
                        quo_next   = '0;
                        big_next   = 1'b0;
                        cnt_next   = DIV_STEPS;
                        state_next = S_QDIV;
                    end
                end
            end

            S_MUL:
            begin
                acc_hi_next = mul_hi;
                acc_lo_next = mul_lo;
                mplier_next = {1'b0, mplier_reg[63:1]};
                cnt_next    = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    p_next     = mul_val;
                    j_next     = j_reg + NW'(1);
                    state_next = S_PWR;
                end
            end

            S_QDIV, S_NDIV, S_RECIP:
            begin
                rem_next = qbit ? (rem_sh - den_reg) : rem_sh;
                quo_next = div_quo;
                big_next = div_big;
                num_next = {num_reg[94:0], 1'b0};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    if (state_reg == S_QDIV)
                    begin
                        q_next     = div_val;
                        state_next = S_SUB;
                    end
                    else if (state_reg == S_NDIV)
                    begin
                        q_next     = div_val;
                        state_next = S_UPD;
                    end
                    else
                    begin
                        res_value_next = div_val;
                        state_next     = S_OUT;
                    end
                end
            end

            S_SUB:
            begin
                // truncating divide of the difference by n
                num_next   = {32'd0, mag64(sub_val)};
                den_next   = 64'(n_reg);
                neg_next   = sub_val[63];
                rem_next   = '0;
                quo_next   = '0;
                big_next   = 1'b0;
                cnt_next   = DIV_STEPS;
                state_next = S_NDIV;
            end

            S_UPD:
            begin
                if (mag64(q_reg) < {32'd0, tol_reg} || it_inc == (ITW+1)'(MAX_ITERATIONS))
                begin
                    if (mag64(q_reg) < {32'd0, tol_reg})
                        res_value_next = y_reg;
                    else
                    begin
                        res_value_next  = y_upd;
                        y_next          = y_upd;
                        res_status_next = ST_NOCONV;
                    end
                    if (negk_reg)
                    begin
                        num_next = {Q_ONE, 32'd0};
                        neg_next = 1'b0;
                        if (mag64(q_reg) < {32'd0, tol_reg})
                        begin
                            den_next = mag64(y_reg);
                            neg_next = y_reg[63];
                        end
                        else
                        begin
                            den_next = mag64(y_upd);
                            neg_next = y_upd[63];
                        end
                        rem_next   = '0;
                        quo_next   = '0;
                        big_next   = 1'b0;
                        cnt_next   = DIV_STEPS;
                        state_next = S_RECIP;
                        // reciprocal of zero saturates positive
                        if (den_next == 64'd0)
                        begin
                            res_value_next = 64'h7FFF_FFFF_FFFF_FFFF;
                            state_next     = S_OUT;
                        end
                    end
                    else
                        state_next = S_OUT;
                end
                else
                begin
                    y_next     = y_upd;
                    it_next    = it_inc[ITW-1:0];
                    p_next     = Q_ONE;
                    j_next     = NW'(1);
                    state_next = S_PWR;
                end
            end

            S_OUT:
            begin
                if (out_ch.ready)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            it_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            it_reg    <= it_next;
        end
    end

    // payload and datapath registers: no reset needed
    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        tol_reg        <= tol_next;
        n_reg          <= n_next;
        j_reg          <= j_next;
        negk_reg       <= negk_next;
        y_reg          <= y_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        cnt_reg        <= cnt_next;
        neg_reg        <= neg_next;
        mcand_reg      <= mcand_next;
        mplier_reg     <= mplier_next;
        acc_hi_reg     <= acc_hi_next;
        acc_lo_reg     <= acc_lo_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        big_reg        <= big_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = (state_reg == S_OUT);
    assign out_ch.root_value = res_value_reg;
    assign out_ch.status     = res_status_reg;

`ifndef ASSERT_OFF
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input and output open together");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status != ST_OK && out_ch.status != ST_NOCONV
        |-> out_ch.root_value == 64'sd0)
        else $error("rejected item with nonzero value");

    a_iter_cap: assert property (@(posedge clk) disable iff (!rst_n)
        int'(it_reg) < MAX_ITERATIONS)
        else $error("iteration count past cap");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("accepted item did not start work");
`endif

endmodule
